// ===== rtl/core/indexed_list_insert_remove_defines.svh =====
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ilir_pkg.sv =====
package ilir_pkg;

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_PUSH   = 3'd4,
        CMD_POP    = 3'd5,
        CMD_RESIZE = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [4:0]         index;
        logic signed [31:0] value;
        logic [4:0]         new_size;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [4:0]         length;
        logic               is_empty;
        t_status            status;
    } t_out;

endpackage

// ===== rtl/core/indexed_list_insert_remove.sv =====
// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_in  (ilir_pkg::t_in)
// output  | o_out_valid| i_out_ready | o_out (ilir_pkg::t_out)
//
// Write, push, pop, clear, shrinking or unchanged resize and failed commands
// answer straight from idle. Read passes through S_RD; insert and remove shift
// the entries from the index on in S_MOVE, and insert then writes the value;
// a growing resize zeroes the new entries in S_FILL. The single write port of
// the entry store moves or fills one entry per cycle.
// Synchronous active-low reset empties the list; entries are not cleared.
// A result waits in the output register; the next item is taken once it drains.
module indexed_list_insert_remove #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ilir_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ilir_pkg::t_out  o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_MOVE,
        S_FILL
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic               r_ovalid;
    ilir_pkg::t_out     r_out;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_dst;
    logic [AW-1:0]      r_idx;
    logic [CW-1:0]      r_left;
    logic               r_up;
    logic               r_ins;
    logic               r_mv;
    logic signed [31:0] r_val;
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_mem [DEPTH];

    logic               in_acc;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      nsz_x;
    logic [XW-1:0]      depth_x;

    t_state             acc_state;
    logic [CW-1:0]      acc_count;
    ilir_pkg::t_status  acc_status;
    logic [CW-1:0]      acc_left;
    logic [AW-1:0]      acc_ptr;
    logic               acc_up;
    logic               acc_ins;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic [AW-1:0]      raddr;

    function automatic ilir_pkg::t_out make_out(input logic signed [31:0] rd,
                                                input logic [CW-1:0] cnt,
                                                input ilir_pkg::t_status st);
        ilir_pkg::t_out o;
        logic [XW-1:0]  cx;
        cx          = XW'(cnt);
        o.read_data = rd;
        o.length    = cx[4:0];
        o.is_empty  = (cnt == '0);
        o.status    = st;
        return o;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    assign idx_x   = XW'(i_in.index);
    assign cnt_x   = XW'(r_count);
    assign nsz_x   = XW'(i_in.new_size);
    assign depth_x = XW'(DEPTH);

    always_comb begin
        acc_state  = S_IDLE;
        acc_count  = r_count;
        acc_status = ilir_pkg::ST_OK;
        acc_left   = '0;
        acc_ptr    = '0;
        acc_up     = 1'b0;
        acc_ins    = 1'b0;
        unique case (i_in.cmd)
            ilir_pkg::CMD_READ: begin
                if (idx_x < cnt_x) acc_state = S_RD;
                else acc_status = ilir_pkg::ST_RANGE;
            end
            ilir_pkg::CMD_WRITE: begin
                if (idx_x >= cnt_x) acc_status = ilir_pkg::ST_RANGE;
            end
            ilir_pkg::CMD_INSERT: begin
                if (idx_x > cnt_x) begin
                    acc_status = ilir_pkg::ST_RANGE;
                end else if (cnt_x >= depth_x) begin
                    acc_status = ilir_pkg::ST_FULL;
                end else begin
                    acc_state = S_MOVE;
                    acc_count = r_count + CW'(1);
                    acc_left  = CW'(cnt_x - idx_x);
                    acc_ptr   = AW'(cnt_x - XW'(1));
                    acc_up    = 1'b1;
                    acc_ins   = 1'b1;
                end
            end
            ilir_pkg::CMD_REMOVE: begin
                if (idx_x >= cnt_x) begin
                    acc_status = ilir_pkg::ST_RANGE;
                end else begin
                    acc_state = S_MOVE;
                    acc_count = r_count - CW'(1);
                    acc_left  = CW'(cnt_x - idx_x - XW'(1));
                    acc_ptr   = AW'(idx_x + XW'(1));
                end
            end
            ilir_pkg::CMD_PUSH: begin
                if (cnt_x >= depth_x) acc_status = ilir_pkg::ST_FULL;
                else acc_count = r_count + CW'(1);
            end
            ilir_pkg::CMD_POP: begin
                if (r_count == '0) acc_status = ilir_pkg::ST_RANGE;
                else acc_count = r_count - CW'(1);
            end
            ilir_pkg::CMD_RESIZE: begin
                if (nsz_x > depth_x) begin
                    acc_status = ilir_pkg::ST_FULL;
                end else begin
                    acc_count = CW'(nsz_x);
                    if (nsz_x > cnt_x) begin
                        acc_state = S_FILL;
                        acc_left  = CW'(nsz_x - cnt_x);
                        acc_ptr   = AW'(cnt_x);
                    end
                end
            end
            ilir_pkg::CMD_CLEAR: begin
                acc_count = '0;
            end
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = r_val;
        raddr = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                raddr = AW'(idx_x);
                if (in_acc && acc_status == ilir_pkg::ST_OK) begin
                    if (i_in.cmd == ilir_pkg::CMD_WRITE) begin
                        we    = 1'b1;
                        waddr = AW'(idx_x);
                        wdata = i_in.value;
                    end else if (i_in.cmd == ilir_pkg::CMD_PUSH) begin
                        we    = 1'b1;
                        waddr = AW'(cnt_x);
                        wdata = i_in.value;
                    end
                end
            end
            S_RD: begin
            end
            S_MOVE: begin
                if (r_mv) begin
                    we    = 1'b1;
                    waddr = r_dst;
                    wdata = r_rdata;
                end else if (r_left == '0 && r_ins) begin
                    we    = 1'b1;
                    waddr = r_idx;
                    wdata = r_val;
                end
            end
            S_FILL: begin
                we    = 1'b1;
                waddr = r_ptr;
                wdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count  <= acc_count;
                        r_state  <= acc_state;
                        r_ptr    <= acc_ptr;
                        r_left   <= acc_left;
                        r_up     <= acc_up;
                        r_ins    <= acc_ins;
                        r_idx    <= AW'(idx_x);
                        r_val    <= i_in.value;
                        r_mv     <= 1'b0;
                        r_ovalid <= (acc_state == S_IDLE);
                        if (acc_state == S_IDLE) begin
                            r_out <= make_out('0, acc_count, acc_status);
                        end
                    end else if (r_ovalid && i_out_ready) begin
                        r_ovalid <= 1'b0;
                    end
                end
                S_RD: begin
                    r_ovalid <= 1'b1;
                    r_out    <= make_out(r_rdata, r_count, ilir_pkg::ST_OK);
                    r_state  <= S_IDLE;
                end
                S_MOVE: begin
                    r_mv  <= (r_left != '0);
                    r_dst <= r_up ? r_ptr + AW'(1) : r_ptr - AW'(1);
                    if (r_left != '0) begin
                        r_left <= r_left - CW'(1);
                        r_ptr  <= r_up ? r_ptr - AW'(1) : r_ptr + AW'(1);
                    end else if (!r_mv) begin
                        r_ovalid <= 1'b1;
                        r_out    <= make_out('0, r_count, ilir_pkg::ST_OK);
                        r_state  <= S_IDLE;
                    end
                end
                S_FILL: begin
                    r_ptr  <= r_ptr + AW'(1);
                    r_left <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_ovalid <= 1'b1;
                        r_out    <= make_out('0, r_count, ilir_pkg::ST_OK);
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ilir_checker.sv =====
`include "indexed_list_insert_remove_defines.svh"

module ilir_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ilir_pkg::t_out o_out
);

    `ILIR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result dropped or changed while stalled")

    `ILIR_ASSERT_NOW(a_empty_flag, o_out_valid, o_out.is_empty == (o_out.length == 5'd0), "empty flag disagrees with length")

    `ILIR_ASSERT_NOW(a_rd_zero, o_out_valid && o_out.status != ilir_pkg::ST_OK, o_out.read_data == 32'sd0, "failed command returned data")

    `ILIR_ASSERT_NOW(a_no_overrun, o_in_ready, !o_out_valid || i_out_ready, "item taken while result pending")

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 1200;
    localparam int HOLD_OFF   = 300;
    localparam int TAIL       = DEPTH + 4;
    localparam int LIMIT      = 500000;

    class t_list_scoreboard;
        logic signed [31:0] words[DEPTH];
        int unsigned        size;
        ilir_pkg::t_out     predicted_results[$];
        int                 errors;

        function new();
            size = 0;
            errors = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_item(ilir_pkg::t_in it);
            ilir_pkg::t_out r;
            int unsigned    idx;
            int unsigned    nsz;
            int unsigned    j;
            r = '0;
            r.status = ilir_pkg::ST_OK;
            idx = 32'(it.index);
            nsz = 32'(it.new_size);
            case (it.cmd)
                ilir_pkg::CMD_READ: begin
                    if (idx < size) r.read_data = words[idx];
                    else r.status = ilir_pkg::ST_RANGE;
                end
                ilir_pkg::CMD_WRITE: begin
                    if (idx < size) words[idx] = it.value;
                    else r.status = ilir_pkg::ST_RANGE;
                end
                ilir_pkg::CMD_INSERT: begin
                    if (idx > size) begin
                        r.status = ilir_pkg::ST_RANGE;
                    end else if (size >= DEPTH) begin
                        r.status = ilir_pkg::ST_FULL;
                    end else begin
                        for (j = size; j > idx; j--) words[j] = words[j - 1];
                        words[idx] = it.value;
                        size++;
                    end
                end
                ilir_pkg::CMD_REMOVE: begin
                    if (idx >= size) begin
                        r.status = ilir_pkg::ST_RANGE;
                    end else begin
                        for (j = idx; j + 1 < size; j++) words[j] = words[j + 1];
                        words[size - 1] = '0;
                        size--;
                    end
                end
                ilir_pkg::CMD_PUSH: begin
                    if (size >= DEPTH) begin
                        r.status = ilir_pkg::ST_FULL;
                    end else begin
                        words[size] = it.value;
                        size++;
                    end
                end
                ilir_pkg::CMD_POP: begin
                    if (size == 0) begin
                        r.status = ilir_pkg::ST_RANGE;
                    end else begin
                        words[size - 1] = '0;
                        size--;
                    end
                end
                ilir_pkg::CMD_RESIZE: begin
                    if (nsz > DEPTH) begin
                        r.status = ilir_pkg::ST_FULL;
                    end else begin
                        for (j = size; j < nsz; j++) words[j] = '0;
                        size = nsz;
                    end
                end
                default: size = 0;
            endcase
            r.length = 5'(size);
            r.is_empty = (size == 0);
            predicted_results = {predicted_results, r};
        endfunction

        task check_result(ilir_pkg::t_out got);
            ilir_pkg::t_out want;
            if (predicted_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", got));
            end else begin
                want = predicted_results.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                        got.read_data, want.read_data));
                if (got.length !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d",
                        got.length, want.length));
                if (got.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %b, want %b",
                        got.is_empty, want.is_empty));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        got.status, want.status));
            end
        endtask
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    ilir_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    ilir_pkg::t_out o_out;

    t_list_scoreboard sb = new();

    int  cycle_count = 0;
    int  items_in = 0;
    bit  hold_off = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;
    bit  rx_want = 1;
    int  rx_left = 0;

    indexed_list_insert_remove #(.DEPTH(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
            if (i_in_valid && o_in_ready) begin
                sb.note_item(i_in);
                items_in++;
            end
        end
    end

    function automatic int idle_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (cycle_count % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        if (rx_left == 0) begin
            if (rx_want) begin
                rx_left = idle_len(rx_quiet);
                if (rx_left != 0) begin
                    rx_want = 0;
                    rx_left--;
                end else begin
                    rx_left = $urandom_range(0, 7);
                end
            end else begin
                rx_want = 1;
                rx_left = $urandom_range(0, 7);
            end
        end else begin
            rx_left--;
        end
        i_out_ready = i_rst_n && rx_want && !hold_off;
    end

    initial begin
        wait (items_in >= 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic ilir_pkg::t_in make_item(ilir_pkg::t_cmd cmd, int idx,
                                                logic [31:0] val, int nsz);
        ilir_pkg::t_in it;
        it.cmd = cmd;
        it.index = 5'(idx);
        it.value = val;
        it.new_size = 5'(nsz);
        return it;
    endfunction

    function automatic ilir_pkg::t_cmd random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return ilir_pkg::CMD_READ;
        if (r < 35) return ilir_pkg::CMD_WRITE;
        if (r < 51) return ilir_pkg::CMD_INSERT;
        if (r < 63) return ilir_pkg::CMD_REMOVE;
        if (r < 77) return ilir_pkg::CMD_PUSH;
        if (r < 87) return ilir_pkg::CMD_POP;
        if (r < 97) return ilir_pkg::CMD_RESIZE;
        return ilir_pkg::CMD_CLEAR;
    endfunction

    function automatic ilir_pkg::t_in random_item();
        ilir_pkg::t_in it;
        int            r;
        int            hint;
        logic [31:0]   val;
        hint = sb.size;
        it.cmd = random_cmd();
        r = $urandom_range(0, 99);
        if (r < 80) it.index = 5'($urandom_range(0, hint));
        else if (r < 95) it.index = 5'($urandom_range(0, DEPTH));
        else it.index = 5'($urandom_range(DEPTH + 1, 31));
        r = $urandom_range(0, 99);
        if (r < 92) it.new_size = 5'($urandom_range(0, DEPTH));
        else it.new_size = 5'($urandom_range(DEPTH + 1, 31));
        case ($urandom_range(0, 19))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            3: val = 32'h0000_0000;
            default: val = $urandom;
        endcase
        it.value = val;
        return it;
    endfunction

    task send_item(ilir_pkg::t_in it);
        i_in_valid = 1'b1;
        i_in = it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task idle_in(int n);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task send_paced(ilir_pkg::t_in it);
        send_item(it);
        idle_in(idle_len(tx_quiet));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_paced(make_item(ilir_pkg::CMD_POP, 0, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_REMOVE, 0, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_READ, 0, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_WRITE, 0, 32'h1111_1111, 0));
        send_paced(make_item(ilir_pkg::CMD_INSERT, 1, 32'h2222_2222, 0));
        send_paced(make_item(ilir_pkg::CMD_INSERT, 0, 32'h7FFF_FFFF, 0));
        send_paced(make_item(ilir_pkg::CMD_PUSH, 0, 32'h8000_0000, 0));
        send_paced(make_item(ilir_pkg::CMD_PUSH, 0, 32'hFFFF_FFFF, 0));
        send_paced(make_item(ilir_pkg::CMD_INSERT, 1, 32'h1234_5678, 0));
        send_paced(make_item(ilir_pkg::CMD_READ, 31, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_WRITE, 3, 32'hA5A5_A5A5, 0));
        send_paced(make_item(ilir_pkg::CMD_READ, 2, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_REMOVE, 1, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_RESIZE, 0, 0, 12));
        send_paced(make_item(ilir_pkg::CMD_RESIZE, 0, 0, 12));
        send_paced(make_item(ilir_pkg::CMD_READ, 11, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_RESIZE, 0, 0, 31));
        send_paced(make_item(ilir_pkg::CMD_RESIZE, 0, 0, DEPTH));
        send_paced(make_item(ilir_pkg::CMD_PUSH, 0, 32'h5A5A_5A5A, 0));
        send_paced(make_item(ilir_pkg::CMD_INSERT, DEPTH, 32'h3333_3333, 0));
        send_paced(make_item(ilir_pkg::CMD_INSERT, DEPTH + 1, 32'h4444_4444, 0));
        send_paced(make_item(ilir_pkg::CMD_REMOVE, DEPTH - 1, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_POP, 0, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_RESIZE, 0, 0, 3));
        send_paced(make_item(ilir_pkg::CMD_CLEAR, 0, 0, 0));
        send_paced(make_item(ilir_pkg::CMD_READ, 0, 0, 0));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            send_paced(random_item());
        end
        i_in_valid = 1'b0;

        while (sb.predicted_results.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
